// ===== sv/touch_slider_led_fade_controller_top_assert.svh =====
// Assertion macros for the touch slider LED fade controller.
`ifndef TOUCH_SLIDER_LED_FADE_CONTROLLER_TOP_ASSERT_SVH
`define TOUCH_SLIDER_LED_FADE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSLF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSLF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tslf_pkg.sv =====
`timescale 1ns / 1ps

package tslf_pkg;

    typedef struct packed {
        logic        scan_done;
        logic [15:0] scan_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] red_duty;
        logic [15:0] green_duty;
        logic [15:0] blue_duty;
        logic        led_enabled;
        logic [1:0]  touch_event;
    } out_item_t;

    typedef struct packed {
        logic [15:0] noise_floor;
        logic [15:0] side_threshold;
        logic [7:0]  debounce_ticks;
        logic [15:0] fade_step;
        logic [15:0] fade_ticks;
    } cfg_t;

    typedef struct packed {
        logic       direction_right;
        logic [1:0] touch_event;
    } touch_res_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } duty_t;

    // register indexes
    localparam logic [2:0] REG_NOISE_FLOOR    = 3'd0;
    localparam logic [2:0] REG_SIDE_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd2;
    localparam logic [2:0] REG_FADE_STEP      = 3'd3;
    localparam logic [2:0] REG_FADE_TICKS     = 3'd4;

    localparam logic [15:0] NOISE_FLOOR_RST    = 16'd40;
    localparam logic [15:0] SIDE_THRESHOLD_RST = 16'h002B;
    localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd10;
    localparam logic [15:0] FADE_STEP_RST      = 16'd13;
    localparam logic [15:0] FADE_TICKS_RST     = 16'd5000;

    localparam logic [15:0] FULL_DUTY = 16'hFFFF;

    // touch event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_LEFT  = 2'd1;
    localparam logic [1:0] EV_RIGHT = 2'd2;

endpackage

// ===== sv/tslf_touch.sv =====
`timescale 1ns / 1ps

module tslf_touch (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  tslf_pkg::in_item_t    item,
    input  tslf_pkg::cfg_t        cfg,
    output tslf_pkg::touch_res_t  res
);

    localparam logic [2:0] TP_IDLE        = 3'd0;
    localparam logic [2:0] TP_DEB_PRESS   = 3'd1;
    localparam logic [2:0] TP_RIGHT       = 3'd2;
    localparam logic [2:0] TP_LEFT        = 3'd3;
    localparam logic [2:0] TP_DEB_RELEASE = 3'd4;

    logic [15:0] reading_reg, reading_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic        dir_reg, dir_next;
    logic [15:0] raw;
    logic [1:0]  event_code;
    logic        is_zero, is_right, deb_done;

    always_comb begin
        raw          = item.scan_done ? item.scan_value : reading_reg;
        reading_next = (raw < cfg.noise_floor) ? 16'd0 : raw;
        is_zero      = (reading_next == 16'd0);
        is_right     = (reading_next < cfg.side_threshold);
        deb_done     = (count_reg >= cfg.debounce_ticks);

        phase_next = phase_reg;
        count_next = count_reg;
        event_code = tslf_pkg::EV_NONE;
        case (phase_reg)
            TP_DEB_PRESS: begin
                if (deb_done) begin
                    phase_next = is_right ? TP_RIGHT : TP_LEFT;
                    count_next = 8'd2;
                end else begin
                    count_next = count_reg + 8'd1;
                end
            end
            TP_RIGHT: begin
                if (is_zero) begin
                    phase_next = TP_DEB_RELEASE;
                end else if (!is_right) begin
                    phase_next = TP_LEFT;
                end else begin
                    event_code = tslf_pkg::EV_RIGHT;
                end
            end
            TP_LEFT: begin
                if (is_zero) begin
                    phase_next = TP_DEB_RELEASE;
                end else if (is_right) begin
                    phase_next = TP_RIGHT;
                end else begin
                    event_code = tslf_pkg::EV_LEFT;
                end
            end
            TP_DEB_RELEASE: begin
                if (deb_done) begin
                    phase_next = TP_IDLE;
                    count_next = 8'd1;
                end else begin
                    count_next = count_reg + 8'd1;
                end
            end
            default: begin
                // a zero reading arms the press debounce
                phase_next = is_zero ? TP_DEB_PRESS : TP_IDLE;
                count_next = is_zero ? 8'd1 : 8'd0;
            end
        endcase

        if (event_code == tslf_pkg::EV_LEFT) begin
            dir_next = 1'b0;
        end else if (event_code == tslf_pkg::EV_RIGHT) begin
            dir_next = 1'b1;
        end else begin
            dir_next = dir_reg;
        end

        res.direction_right = dir_next;
        res.touch_event     = event_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_reg <= '0;
            phase_reg   <= TP_IDLE;
            count_reg   <= '0;
            dir_reg     <= 1'b0;
        end else if (step) begin
            reading_reg <= reading_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            dir_reg     <= dir_next;
        end
    end

endmodule

// ===== sv/tslf_fade.sv =====
`timescale 1ns / 1ps

module tslf_fade (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             enable,
    input  tslf_pkg::cfg_t   cfg,
    output tslf_pkg::duty_t  duty
);

    localparam logic [1:0] FP_START = 2'd0;
    localparam logic [1:0] FP_RED   = 2'd1;
    localparam logic [1:0] FP_GREEN = 2'd2;
    localparam logic [1:0] FP_BLUE  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] red_reg, red_next;
    logic [15:0] green_reg, green_next;
    logic [15:0] blue_reg, blue_next;
    logic [1:0]  cur_phase, adv_phase;
    logic [15:0] red_base, count_inc;
    tslf_pkg::duty_t fade_out;

    always_comb begin
        // start phase loads full red and runs as the red phase this tick
        cur_phase  = (phase_reg == FP_START) ? FP_RED : phase_reg;
        red_base   = (phase_reg == FP_START) ? tslf_pkg::FULL_DUTY : red_reg;
        count_inc  = count_reg + 16'd1;
        red_next   = red_base;
        green_next = green_reg;
        blue_next  = blue_reg;
        fade_out   = '0;
        case (cur_phase)
            FP_RED: begin
                red_next       = red_base - cfg.fade_step;
                green_next     = green_reg + cfg.fade_step;
                fade_out.red   = red_next;
                fade_out.green = green_next;
                adv_phase      = FP_GREEN;
            end
            FP_GREEN: begin
                green_next     = green_reg - cfg.fade_step;
                blue_next      = blue_reg + cfg.fade_step;
                fade_out.green = green_next;
                fade_out.blue  = blue_next;
                adv_phase      = FP_BLUE;
            end
            default: begin
                blue_next     = blue_reg - cfg.fade_step;
                red_next      = red_base + cfg.fade_step;
                fade_out.red  = red_next;
                fade_out.blue = blue_next;
                adv_phase     = FP_RED;
            end
        endcase
        if (count_inc >= cfg.fade_ticks) begin
            phase_next = adv_phase;
            count_next = 16'd0;
        end else begin
            phase_next = cur_phase;
            count_next = count_inc;
        end
        duty = enable ? fade_out : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= FP_START;
            count_reg <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end else if (step && enable) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// ===== sv/touch_slider_led_fade_controller_top.sv =====
`timescale 1ns / 1ps
// Path: an input transaction is held in the input reg, then in the result reg; m_valid rises
// when the result reg is loaded. The touch and fade state update in one pass.
// Throughput: one transaction per cycle while m_ready does not stall the result register.
// A stalled result register holds the input stage, which then lowers s_ready.
// Reset (aresetn low, synchronous): empty pipeline, idle touch machine, LED off,
// fade at its start phase, all levels zero, configuration at defaults.
`include "touch_slider_led_fade_controller_top_assert.svh"

module touch_slider_led_fade_controller_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tslf_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output tslf_pkg::out_item_t m_payload,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    tslf_pkg::cfg_t      cfg_reg;
    tslf_pkg::in_item_t  in_data_reg;
    logic                in_valid_reg;
    tslf_pkg::out_item_t out_data_reg, out_data_next;
    logic                out_valid_reg;
    logic                advance;
    tslf_pkg::touch_res_t touch_res;
    tslf_pkg::duty_t     duty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.noise_floor    <= tslf_pkg::NOISE_FLOOR_RST;
            cfg_reg.side_threshold <= tslf_pkg::SIDE_THRESHOLD_RST;
            cfg_reg.debounce_ticks <= tslf_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.fade_step      <= tslf_pkg::FADE_STEP_RST;
            cfg_reg.fade_ticks     <= tslf_pkg::FADE_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tslf_pkg::REG_NOISE_FLOOR:    cfg_reg.noise_floor    <= cfg_data;
                tslf_pkg::REG_SIDE_THRESHOLD: cfg_reg.side_threshold <= cfg_data;
                tslf_pkg::REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[7:0];
                tslf_pkg::REG_FADE_STEP:      cfg_reg.fade_step      <= cfg_data;
                tslf_pkg::REG_FADE_TICKS:     cfg_reg.fade_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    // the buffered transaction moves on when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

    tslf_touch u_touch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .res     (touch_res)
    );

    tslf_fade u_fade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .enable  (touch_res.direction_right),
        .cfg     (cfg_reg),
        .duty    (duty)
    );

    always_comb begin
        out_data_next.red_duty    = duty.red;
        out_data_next.green_duty  = duty.green;
        out_data_next.blue_duty   = duty.blue;
        out_data_next.led_enabled = touch_res.direction_right;
        out_data_next.touch_event = touch_res.touch_event;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    `TSLF_ASSERT_NOW(a_off_duties_zero, aclk, aresetn,
        m_valid && !m_payload.led_enabled,
        m_payload.red_duty == 16'd0 && m_payload.green_duty == 16'd0
            && m_payload.blue_duty == 16'd0,
        "duty nonzero while LED is off")
    `TSLF_ASSERT_NOW(a_event_sets_dir, aclk, aresetn,
        m_valid && (m_payload.touch_event == tslf_pkg::EV_RIGHT
            || m_payload.touch_event == tslf_pkg::EV_LEFT),
        m_payload.led_enabled == (m_payload.touch_event == tslf_pkg::EV_RIGHT),
        "held side does not match LED enable")
    `TSLF_ASSERT_NEXT(a_stalled_item_kept, aclk, aresetn,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_data_reg),
        "buffered transaction lost while stalled")

endmodule
